FILE: rtl/dq_pkg.sv
// Shared types, operation codes and status codes for the double-ended queue.
package dq_pkg;

  // Field widths fixed by the item format.
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  // Default ring capacity in words.
  localparam int DEPTH_DEFAULT = 16;

  typedef logic        [OP_W-1:0]   op_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic        [ST_W-1:0]   status_t;

  // Operation codes.
  localparam op_t OP_PUSH_BACK  = 2'd0;
  localparam op_t OP_PUSH_FRONT = 2'd1;
  localparam op_t OP_POP_BACK   = 2'd2;
  localparam op_t OP_POP_FRONT  = 2'd3;

  // Status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Word returned by a pop on an empty queue.
  localparam word_t EMPTY_VALUE = '1;

endpackage

FILE: rtl/dq_if.sv
// Valid/ready channel interfaces for operation items and result items.
interface dq_in_if;
  import dq_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  word_t push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;

  logic    valid;
  logic    ready;
  word_t   pop_value;
  status_t status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

FILE: rtl/double_ended_queue_ring.sv
// Double-ended queue of signed 32-bit words held in a ring memory.
//
//   Channel | Direction | Payload                      | Handshake
//   --------+-----------+------------------------------+------------
//   in_ch   | input     | op, push_value               | valid/ready
//   out_ch  | output    | pop_value, status            | valid/ready
//
// The result of a push, a rejected push or a pop on an empty queue is registered
// in the cycle after the item is taken. A pop that reads the ring passes through
// the registered memory read port (rd_data_r) and then into the result register.
// A new item is taken when the block is idle and the result register is empty
// or is being emptied in the same cycle; a stalled result holds off input.
// Reset (synchronous, active low) empties the queue but leaves the ring memory as is.
module double_ended_queue_ring #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input logic     clk,
  input logic     rst_n,
  dq_in_if.sink   in_ch,
  dq_out_if.source out_ch
);
  import dq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Sequencer states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  // Ring memory.
  word_t mem [DEPTH];

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_value_r, out_value_nxt;
  status_t          out_status_r, out_status_nxt;
  word_t            rd_data_r;

  logic             accept;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // Input is taken when idle and the result register has room at this edge.
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = out_value_r;
  assign out_ch.status    = out_status_r;

  // Decode the operation: pointer updates, memory access and result.
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = back_r;
    rd_addr        = front_r;

    if (state_r == S_READ) begin
      // The read word is ready; hand it to the result register.
      out_valid_nxt  = 1'b1;
      out_value_nxt  = rd_data_r;
      out_status_nxt = ST_OK;
      state_nxt      = S_IDLE;
    end else if (accept) begin
      out_value_nxt  = '0;
      out_status_nxt = ST_OK;
      case (in_ch.op)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          out_valid_nxt = 1'b1;
          if (count_r == FULL_CNT) begin
            out_status_nxt = ST_FULL;
          end else if (in_ch.op == OP_PUSH_BACK) begin
            wr_en     = 1'b1;
            wr_addr   = back_r;
            back_nxt  = idx_inc(back_r);
            count_nxt = count_r + 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = idx_dec(front_r);
            front_nxt = idx_dec(front_r);
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_BACK, OP_POP_FRONT: begin
          if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = EMPTY_VALUE;
            out_status_nxt = ST_EMPTY;
          end else if (in_ch.op == OP_POP_BACK) begin
            rd_en     = 1'b1;
            rd_addr   = idx_dec(back_r);
            back_nxt  = idx_dec(back_r);
            count_nxt = count_r - 1'b1;
            state_nxt = S_READ;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = front_r;
            front_nxt = idx_inc(front_r);
            count_nxt = count_r - 1'b1;
            state_nxt = S_READ;
          end
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ch.ready;
        end
      endcase
    end
  end

  // Memory write and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ch.push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

FILE: rtl/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module dq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input dq_pkg::word_t     pop_value,
  input dq_pkg::status_t   status
);
  import dq_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A pop on an empty queue always answers the all-ones word.
  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> pop_value == EMPTY_VALUE)
    else $error("empty pop did not return -1");

  // A rejected push answers zero.
  a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> pop_value == '0)
    else $error("rejected push did not return zero");

  // No item is taken while a result waits unclaimed.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("item taken while result register is blocked");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind double_ended_queue_ring dq_checker u_dq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pop_value (out_ch.pop_value),
  .status    (out_ch.status)
);
